// File: rtl/core/war_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// war_pkg
// Shared types, register indexes and helper functions for the weekly alarm
// register planner.
// ----------------------------------------------------------------------------
package war_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_WEEKDAY_MASK = 2'd0;
  localparam logic [1:0] CFG_ALARM_HOUR   = 2'd1;
  localparam logic [1:0] CFG_ALARM_MINUTE = 2'd2;
  localparam logic [1:0] CFG_ALARM_ENABLE = 2'd3;

  // hour codes
  localparam logic [5:0] HOUR_MIDNIGHT = 6'h12;
  localparam logic [5:0] HOUR_NOON     = 6'h32;
  localparam logic [5:0] HOUR_PM_BASE  = 6'h20;
  localparam logic [7:0] RTC_NOON      = 8'h40;
  localparam logic [7:0] RTC_PM_FLAG   = 8'h20;
  localparam logic [7:0] BYTE_ENABLE   = 8'h01;

  localparam logic [2:0] DAY_SUNDAY = 3'd0;
  localparam logic [2:0] DAY_LAST   = 3'd6;

  // stage 1 word: time compare and mask flags
  typedef struct packed {
    logic [2:0] today;
    logic       passed;
    logic       multi;
  } war_s1_t;

  // stage 2 word: chosen first alarm day
  typedef struct packed {
    logic [2:0] first;
    logic       multi;
  } war_s2_t;

  // reverse the bit order of a byte
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // 12-hour code to the rtc am/pm code
  function automatic logic [7:0] to_rtc_hour(input logic [5:0] h);
    logic [7:0] r;
    if (h == HOUR_MIDNIGHT) begin
      r = 8'h00;
    end else if (h == HOUR_NOON) begin
      r = RTC_NOON;
    end else if (h > HOUR_PM_BASE) begin
      r = {2'b00, h} + RTC_PM_FLAG;
    end else begin
      r = {2'b00, h};
    end
    return r;
  endfunction

  // hour code folded so that raw compares follow the clock
  function automatic logic [5:0] linear_hour(input logic [5:0] h);
    logic [5:0] r;
    if (h == HOUR_MIDNIGHT) begin
      r = 6'h00;
    end else if (h == HOUR_NOON) begin
      r = HOUR_MIDNIGHT;
    end else begin
      r = h;
    end
    return r;
  endfunction

  // next weekday, wrapping saturday to sunday
  function automatic logic [2:0] inc7(input logic [2:0] d);
    logic [2:0] r;
    if (d >= DAY_LAST) begin
      r = DAY_SUNDAY;
    end else begin
      r = d + 3'd1;
    end
    return r;
  endfunction

  // first selected day at or after start
  function automatic logic [2:0] next_day(input logic [6:0] days, input logic [2:0] start);
    logic [3:0] sum;
    logic [2:0] d;
    logic [2:0] r;
    r = start;
    for (int k = 6; k >= 0; k--) begin
      sum = {1'b0, start} + 4'(k);
      if (sum >= 4'd7) begin
        sum = sum - 4'd7;
      end
      d = sum[2:0];
      if (days[d]) begin
        r = d;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/war_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// war_prep
// Stage 1: folds the weekday, compares current time against the alarm time
// and flags a mask with two or more days.
// ----------------------------------------------------------------------------
module war_prep (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic [2:0]           cur_weekday,
  input  wire logic [5:0]           cur_hour,
  input  wire logic [6:0]           cur_minute,
  input  wire logic [6:0]           days,
  input  wire logic [5:0]           alarm_hour,
  input  wire logic [6:0]           alarm_minute,
  input  wire logic                 dn_ready,
  output logic                      s1_valid_r,
  output war_pkg::war_s1_t          s1_r
);
  import war_pkg::*;

  war_s1_t    s1_nxt;
  logic [5:0] cur_lin;
  logic [5:0] alm_lin;

  // time compare and day flags
  always_comb begin
    cur_lin        = linear_hour(cur_hour);
    alm_lin        = linear_hour(alarm_hour);
    s1_nxt.today   = (cur_weekday > DAY_LAST) ? DAY_SUNDAY : cur_weekday;
    s1_nxt.passed  = (cur_lin > alm_lin) ||
                     ((cur_lin == alm_lin) && (cur_minute >= alarm_minute));
    s1_nxt.multi   = ((days & (days - 7'd1)) != 7'd0);
  end

  assign up_ready = !s1_valid_r || dn_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (up_ready) begin
      s1_valid_r <= up_valid;
    end
  end

  // stage word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1_r <= s1_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/war_dsel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// war_dsel
// Stage 2: picks the first alarm day, skipping today when the alarm time has
// been reached and more than one day is selected.
// ----------------------------------------------------------------------------
module war_dsel (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire war_pkg::war_s1_t     s1,
  input  wire logic [6:0]           days,
  input  wire logic                 dn_ready,
  output logic                      s2_valid_r,
  output war_pkg::war_s2_t          s2_r
);
  import war_pkg::*;

  war_s2_t    s2_nxt;
  logic [2:0] day_today;
  logic [2:0] day_after;
  logic       skip;

  // both candidates searched side by side
  always_comb begin
    day_today    = next_day(days, s1.today);
    day_after    = next_day(days, inc7(s1.today));
    skip         = s1.multi && days[s1.today] && s1.passed;
    s2_nxt.first = skip ? day_after : day_today;
    s2_nxt.multi = s1.multi;
  end

  assign up_ready = !s2_valid_r || dn_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (up_ready) begin
      s2_valid_r <= up_valid;
    end
  end

  // stage word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/war_enc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// war_enc
// Stage 3: finds the second alarm day, builds the bit-reversed register
// bytes and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module war_enc (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire war_pkg::war_s2_t     s2,
  input  wire logic [7:0]           weekday_mask,
  input  wire logic [5:0]           alarm_hour,
  input  wire logic [6:0]           alarm_minute,
  input  wire logic                 alarm_enable,
  input  wire logic                 out_stall,
  output logic                      out_valid_r,
  output logic [7:0]                int1_day_r,
  output logic [7:0]                int1_hour_r,
  output logic [7:0]                int1_minute_r,
  output logic [7:0]                int2_day_r,
  output logic [7:0]                int2_hour_r,
  output logic [7:0]                int2_minute_r,
  output logic [7:0]                spare_r,
  output logic                      status_r
);
  import war_pkg::*;

  logic [6:0] days;
  logic [2:0] second;
  logic [7:0] hour_b;
  logic [7:0] min_b;
  logic [7:0] int1_day_nxt;
  logic [7:0] int1_hour_nxt;
  logic [7:0] int1_minute_nxt;
  logic [7:0] int2_day_nxt;
  logic [7:0] int2_hour_nxt;
  logic [7:0] int2_minute_nxt;
  logic [7:0] spare_nxt;
  logic       status_nxt;

  // byte encoding per mode
  always_comb begin
    days            = weekday_mask[6:0];
    second          = next_day(days, inc7(s2.first));
    hour_b          = rev8(to_rtc_hour(alarm_hour)) | BYTE_ENABLE;
    min_b           = rev8({1'b0, alarm_minute}) | BYTE_ENABLE;
    int1_day_nxt    = 8'h00;
    int1_hour_nxt   = 8'h00;
    int1_minute_nxt = 8'h00;
    int2_day_nxt    = 8'h00;
    int2_hour_nxt   = 8'h00;
    int2_minute_nxt = 8'h00;
    spare_nxt       = weekday_mask;
    status_nxt      = 1'b0;
    if (alarm_enable) begin
      if (days == 7'd0) begin
        spare_nxt  = 8'h00;
        status_nxt = 1'b1;
      end else begin
        int1_day_nxt    = rev8({5'd0, s2.first}) | BYTE_ENABLE;
        int1_hour_nxt   = hour_b;
        int1_minute_nxt = min_b;
        if (s2.multi) begin
          int2_day_nxt    = rev8({5'd0, second}) | BYTE_ENABLE;
          int2_hour_nxt   = hour_b;
          int2_minute_nxt = min_b;
        end
      end
    end
  end

  assign up_ready = !out_valid_r || !out_stall;

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      int1_day_r    <= int1_day_nxt;
      int1_hour_r   <= int1_hour_nxt;
      int1_minute_r <= int1_minute_nxt;
      int2_day_r    <= int2_day_nxt;
      int2_hour_r   <= int2_hour_nxt;
      int2_minute_r <= int2_minute_nxt;
      spare_r       <= spare_nxt;
      status_r      <= status_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/weekly_alarm_register_planner_top.sv
`default_nettype none
// Throughput: one word per cycle while out_stall is low; an accepted input word
// reaches out_* through three register stages (time compare, first day pick,
// second day pick and byte encoding with the output register).
// in_stall rises only when every stage holds a word and out_stall is high.
// Reset (rst_n low, synchronous) empties the pipeline and loads the config
// registers with mask 0, hour code 0x12, minute 0 and alarm disabled.
// ----------------------------------------------------------------------------
// weekly_alarm_register_planner_top
// Plans the two rtc alarm register triples and the spare byte from the
// current weekday and time and the configured weekly alarm.
// ----------------------------------------------------------------------------
module weekly_alarm_register_planner_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_current_weekday,
  input  wire logic [5:0] in_current_hour,
  input  wire logic [6:0] in_current_minute,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_int1_day_byte,
  output logic [7:0]      out_int1_hour_byte,
  output logic [7:0]      out_int1_minute_byte,
  output logic [7:0]      out_int2_day_byte,
  output logic [7:0]      out_int2_hour_byte,
  output logic [7:0]      out_int2_minute_byte,
  output logic [7:0]      out_spare_byte,
  output logic            out_status
);
  import war_pkg::*;

  logic [7:0] weekday_mask_r;
  logic [5:0] alarm_hour_r;
  logic [6:0] alarm_minute_r;
  logic       alarm_enable_r;

  logic       s1_ready;
  logic       s1_valid;
  war_s1_t    s1;
  logic       s2_ready;
  logic       s2_valid;
  war_s2_t    s2;
  logic       s3_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weekday_mask_r <= 8'h00;
      alarm_hour_r   <= HOUR_MIDNIGHT;
      alarm_minute_r <= 7'h00;
      alarm_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WEEKDAY_MASK: weekday_mask_r <= cfg_wdata;
        CFG_ALARM_HOUR:   alarm_hour_r   <= cfg_wdata[5:0];
        CFG_ALARM_MINUTE: alarm_minute_r <= cfg_wdata[6:0];
        CFG_ALARM_ENABLE: alarm_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = !s1_ready;

  // stage 1: time compare
  war_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (s1_ready),
    .cur_weekday  (in_current_weekday),
    .cur_hour     (in_current_hour),
    .cur_minute   (in_current_minute),
    .days         (weekday_mask_r[6:0]),
    .alarm_hour   (alarm_hour_r),
    .alarm_minute (alarm_minute_r),
    .dn_ready     (s2_ready),
    .s1_valid_r   (s1_valid),
    .s1_r         (s1)
  );

  // stage 2: first day
  war_dsel u_dsel (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (s1_valid),
    .up_ready   (s2_ready),
    .s1         (s1),
    .days       (weekday_mask_r[6:0]),
    .dn_ready   (s3_ready),
    .s2_valid_r (s2_valid),
    .s2_r       (s2)
  );

  // stage 3: second day, encoding, output register
  war_enc u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (s2_valid),
    .up_ready      (s3_ready),
    .s2            (s2),
    .weekday_mask  (weekday_mask_r),
    .alarm_hour    (alarm_hour_r),
    .alarm_minute  (alarm_minute_r),
    .alarm_enable  (alarm_enable_r),
    .out_stall     (out_stall),
    .out_valid_r   (out_valid),
    .int1_day_r    (out_int1_day_byte),
    .int1_hour_r   (out_int1_hour_byte),
    .int1_minute_r (out_int1_minute_byte),
    .int2_day_r    (out_int2_day_byte),
    .int2_hour_r   (out_int2_hour_byte),
    .int2_minute_r (out_int2_minute_byte),
    .spare_r       (out_spare_byte),
    .status_r      (out_status)
  );

`ifndef SYNTHESIS
  // error word carries no alarm and no spare byte
  a_status_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_int1_day_byte == 8'h00 &&
      out_int2_day_byte == 8'h00 && out_spare_byte == 8'h00))
    else $error("status word carries alarm bytes");

  // second alarm only exists with a first alarm
  a_int2_needs_int1 : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_int2_day_byte[0]) |-> out_int1_day_byte[0])
    else $error("int2 armed without int1");

  // an armed int1 triple has all three enable bits
  a_int1_triple : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_int1_day_byte[0]) |->
      (out_int1_hour_byte[0] && out_int1_minute_byte[0]))
    else $error("int1 triple partly armed");

  // empty pipeline never stalls the input
  a_no_stall_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !s1_valid && !s2_valid) |-> !in_stall)
    else $error("input stalled with empty pipeline");
`endif

endmodule
`default_nettype wire

// File: verif/weekly_alarm_register_planner_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weekly_alarm_register_planner_top_tb
// Drives weekday and time words into the planner under a series of alarm
// settings. Each result word is checked field by field against a plan
// computed in the bench from the same settings. Covers disabled, empty mask,
// single day and multi day cases, with random gaps on both sides and four
// long holds on the result side.
// ----------------------------------------------------------------------------
module weekly_alarm_register_planner_top_tb;
  import war_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          PHASES       = 24;
  localparam int          PHASE_WORDS  = 70;

  // one planned set of rtc alarm registers
  typedef struct packed {
    logic [7:0] i1_day;
    logic [7:0] i1_hour;
    logic [7:0] i1_min;
    logic [7:0] i2_day;
    logic [7:0] i2_hour;
    logic [7:0] i2_min;
    logic [7:0] spare;
    logic       status;
  } alarm_regs_t;

  // alarm plan prediction and result checking
  class alarm_plan_board;
    logic [7:0]  reg_mask   = 8'h00;
    logic [5:0]  reg_hour   = HOUR_MIDNIGHT;
    logic [6:0]  reg_minute = 7'h00;
    logic        reg_enable = 1'b0;
    alarm_regs_t planned_q[$];
    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned empty_mask    = 0;
    int unsigned two_alarms    = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_WEEKDAY_MASK: reg_mask   = val;
        CFG_ALARM_HOUR:   reg_hour   = val[5:0];
        CFG_ALARM_MINUTE: reg_minute = val[6:0];
        CFG_ALARM_ENABLE: reg_enable = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] flip8(logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
    endfunction

    function logic [7:0] rtc_code(logic [5:0] h);
      if (h == HOUR_MIDNIGHT) return 8'h00;
      if (h == HOUR_NOON) return RTC_NOON;
      if (h > HOUR_PM_BASE) return {2'b00, h} + RTC_PM_FLAG;
      return {2'b00, h};
    endfunction

    // midnight sorts first, noon sorts right after eleven
    function logic [5:0] clock_order(logic [5:0] h);
      if (h == HOUR_MIDNIGHT) return 6'h00;
      if (h == HOUR_NOON) return HOUR_MIDNIGHT;
      return h;
    endfunction

    function logic [2:0] seek_day(logic [6:0] days, logic [2:0] start);
      int d;
      for (int k = 0; k < 7; k++) begin
        d = (int'(start) + k) % 7;
        if (days[d]) return 3'(d);
      end
      return start;
    endfunction

    function logic [2:0] day_after(logic [2:0] d);
      return (d >= DAY_LAST) ? DAY_SUNDAY : d + 3'd1;
    endfunction

    function alarm_regs_t plan_alarm(logic [2:0] wd, logic [5:0] hr, logic [6:0] mn);
      alarm_regs_t r;
      logic [6:0]  days;
      logic [2:0]  today;
      logic [2:0]  lead_day;
      logic [2:0]  later_day;
      logic [5:0]  now_h;
      logic [5:0]  set_h;
      logic        reached;
      int          n;
      r = '0;
      days = reg_mask[6:0];
      today = (wd > DAY_LAST) ? DAY_SUNDAY : wd;
      n = $countones(days);
      if (!reg_enable) begin
        r.spare = reg_mask;
        return r;
      end
      if (n == 0) begin
        r.status = 1'b1;
        return r;
      end
      now_h = clock_order(hr);
      set_h = clock_order(reg_hour);
      reached = (now_h > set_h) || (now_h == set_h && mn >= reg_minute);
      lead_day = seek_day(days, today);
      if (n >= 2 && lead_day == today && reached) lead_day = seek_day(days, day_after(today));
      r.i1_day  = flip8({5'b0, lead_day}) | BYTE_ENABLE;
      r.i1_hour = flip8(rtc_code(reg_hour)) | BYTE_ENABLE;
      r.i1_min  = flip8({1'b0, reg_minute}) | BYTE_ENABLE;
      if (n >= 2) begin
        later_day = seek_day(days, day_after(lead_day));
        r.i2_day  = flip8({5'b0, later_day}) | BYTE_ENABLE;
        r.i2_hour = r.i1_hour;
        r.i2_min  = r.i1_min;
      end
      r.spare = reg_mask;
      return r;
    endfunction

    function void note_input(logic [2:0] wd, logic [5:0] hr, logic [6:0] mn);
      planned_q.push_back(plan_alarm(wd, hr, mn));
    endfunction

    function int pending();
      return planned_q.size();
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t mismatch %s: expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(alarm_regs_t got);
      alarm_regs_t want;
      if (planned_q.size() == 0) begin
        mismatches++;
        $display("%0t mismatch word: expected none got %h", $time, got);
        return;
      end
      want = planned_q.pop_front();
      words_checked++;
      if (want.status) empty_mask++;
      if (want.i2_day != 8'h00) two_alarms++;
      cmp_field("int1_day_byte", want.i1_day, got.i1_day);
      cmp_field("int1_hour_byte", want.i1_hour, got.i1_hour);
      cmp_field("int1_minute_byte", want.i1_min, got.i1_min);
      cmp_field("int2_day_byte", want.i2_day, got.i2_day);
      cmp_field("int2_hour_byte", want.i2_hour, got.i2_hour);
      cmp_field("int2_minute_byte", want.i2_min, got.i2_min);
      cmp_field("spare_byte", want.spare, got.spare);
      cmp_field("status", {7'b0, want.status}, {7'b0, got.status});
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_current_weekday;
  logic [5:0] in_current_hour;
  logic [6:0] in_current_minute;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_int1_day_byte;
  logic [7:0] out_int1_hour_byte;
  logic [7:0] out_int1_minute_byte;
  logic [7:0] out_int2_day_byte;
  logic [7:0] out_int2_hour_byte;
  logic [7:0] out_int2_minute_byte;
  logic [7:0] out_spare_byte;
  logic       out_status;

  alarm_plan_board sb = new;
  alarm_regs_t     seen_word;
  int unsigned     cycle_cnt    = 0;
  int unsigned     settings_cnt = 0;
  int              tx_idle_pct  = 0;
  int              rx_stall_pct = 0;
  int              hold_ask     = 0;
  int              hold_seen    = 0;
  int              hold_left    = 0;
  logic [5:0]      cur_al_hour  = HOUR_MIDNIGHT;
  logic [6:0]      cur_al_min   = 7'h00;

  weekly_alarm_register_planner_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_current_weekday   (in_current_weekday),
    .in_current_hour      (in_current_hour),
    .in_current_minute    (in_current_minute),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_int1_day_byte    (out_int1_day_byte),
    .out_int1_hour_byte   (out_int1_hour_byte),
    .out_int1_minute_byte (out_int1_minute_byte),
    .out_int2_day_byte    (out_int2_day_byte),
    .out_int2_hour_byte   (out_int2_hour_byte),
    .out_int2_minute_byte (out_int2_minute_byte),
    .out_spare_byte       (out_spare_byte),
    .out_status           (out_status)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stall, with a long hold on request
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_word.i1_day  = out_int1_day_byte;
      seen_word.i1_hour = out_int1_hour_byte;
      seen_word.i1_min  = out_int1_minute_byte;
      seen_word.i2_day  = out_int2_day_byte;
      seen_word.i2_hour = out_int2_hour_byte;
      seen_word.i2_min  = out_int2_minute_byte;
      seen_word.spare   = out_spare_byte;
      seen_word.status  = out_status;
      sb.check_result(seen_word);
    end
  end

  function automatic logic [7:0] to_bcd(int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // mostly legal 12-hour codes, some raw 6-bit values
  function automatic logic [5:0] pick_hour();
    int         h;
    logic [7:0] b;
    if ($urandom_range(0, 9) < 2) return 6'($urandom_range(0, 63));
    h = $urandom_range(1, 12);
    b = to_bcd(h);
    if ($urandom_range(0, 1) == 1) return (h == 12) ? HOUR_NOON : 6'(b + {2'b00, HOUR_PM_BASE});
    return (h == 12) ? HOUR_MIDNIGHT : b[5:0];
  endfunction

  function automatic logic [6:0] pick_minute();
    if ($urandom_range(0, 9) < 2) return 7'($urandom_range(0, 127));
    return 7'(to_bcd($urandom_range(0, 59)));
  endfunction

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // offer one word, with random sender gaps ahead of it
  task automatic send_word(logic [2:0] wd, logic [5:0] hr, logic [6:0] mn);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid           <= 1'b0;
      in_current_weekday <= 3'($urandom_range(0, 7));
      in_current_hour    <= 6'($urandom_range(0, 63));
      in_current_minute  <= 7'($urandom_range(0, 127));
      @(posedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_current_weekday <= wd;
    in_current_hour    <= hr;
    in_current_minute  <= mn;
    do @(posedge clk); while (in_stall);
    sb.note_input(wd, hr, mn);
  endtask

  // drain the pipeline, then load a full alarm setting
  task automatic new_setting(logic [7:0] mask, logic [5:0] hr, logic [6:0] mn, logic en,
                             bit squeeze);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (squeeze) hold_ask++;
    write_cfg(CFG_WEEKDAY_MASK, mask);
    write_cfg(CFG_ALARM_HOUR, {2'b00, hr});
    write_cfg(CFG_ALARM_MINUTE, {1'b0, mn});
    write_cfg(CFG_ALARM_ENABLE, {7'b0, en});
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_al_hour = hr;
    cur_al_min  = mn;
    settings_cnt++;
  endtask

  initial begin
    logic [7:0] mask;
    logic [2:0] wd;
    logic [5:0] hr;
    logic [6:0] mn;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_WEEKDAY_MASK;
    cfg_wdata          = 8'h00;
    in_valid           = 1'b0;
    in_current_weekday = DAY_SUNDAY;
    in_current_hour    = 6'h00;
    in_current_minute  = 7'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, alarm disabled
    send_word(DAY_SUNDAY, HOUR_MIDNIGHT, 7'h00);
    send_word(3'd7, 6'h3f, 7'h7f);
    // disabled with full mask and extreme time codes
    new_setting(8'hff, 6'h3f, 7'h7f, 1'b0, 1'b0);
    send_word(DAY_LAST, 6'h00, 7'h00);
    // enabled with no weekday, only the spare bit set
    new_setting(8'h80, 6'h11, 7'h30, 1'b1, 1'b0);
    send_word(3'd3, HOUR_NOON, 7'h59);
    // single day: today counts even when the time has passed
    new_setting(8'h08, HOUR_NOON, 7'h30, 1'b1, 1'b0);
    send_word(3'd3, 6'h31, 7'h59);
    send_word(3'd2, 6'h01, 7'h00);
    send_word(3'd4, HOUR_NOON, 7'h30);
    // two days: skip today once the alarm time is reached
    new_setting(8'h41, 6'h11, 7'h45, 1'b1, 1'b0);
    send_word(DAY_LAST, 6'h11, 7'h44);
    send_word(DAY_LAST, 6'h11, 7'h45);
    send_word(DAY_LAST, HOUR_MIDNIGHT, 7'h59);
    send_word(DAY_LAST, HOUR_NOON, 7'h00);
    send_word(3'd7, 6'h11, 7'h45);
    send_word(DAY_SUNDAY, 6'h21, 7'h00);
    // every day, midnight alarm
    new_setting(8'h7f, HOUR_MIDNIGHT, 7'h00, 1'b1, 1'b0);
    send_word(3'd5, HOUR_MIDNIGHT, 7'h00);
    send_word(DAY_SUNDAY, 6'h01, 7'h00);
    // out-of-range codes pass straight through
    new_setting(8'hff, 6'h3f, 7'h7f, 1'b1, 1'b0);
    send_word(3'd1, 6'h3f, 7'h7f);
    send_word(3'd1, 6'h3f, 7'h7e);
    send_word(3'd1, 6'h00, 7'h00);
    new_setting(8'h2a, 6'h00, 7'h00, 1'b1, 1'b0);
    send_word(3'd1, 6'h00, 7'h00);
    send_word(3'd3, HOUR_PM_BASE, 7'h05);
    send_word(3'd5, 6'h21, 7'h00);

    // random phases with varying gap patterns
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       mask = {1'($urandom_range(0, 1)), 7'b0};
        1, 2, 3: mask = 8'(1 << $urandom_range(0, 6)) | {1'($urandom_range(0, 1)), 7'b0};
        default: mask = 8'($urandom_range(0, 255));
      endcase
      new_setting(mask, pick_hour(), pick_minute(), $urandom_range(0, 99) < 85, p % 6 == 0);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        wd = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 4) < 2) begin
          // close to the alarm time, where the skip decision is made
          hr = cur_al_hour;
          case ($urandom_range(0, 3))
            0:       mn = cur_al_min;
            1:       mn = cur_al_min + 7'd1;
            2:       mn = cur_al_min - 7'd1;
            default: mn = pick_minute();
          endcase
        end else begin
          hr = pick_hour();
          mn = pick_minute();
        end
        send_word(wd, hr, mn);
      end
    end

    // drain and let the pipeline settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    rx_stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("tb: checked %0d result words across %0d alarm settings", sb.words_checked,
             settings_cnt);
    $display("tb: %0d empty-mask errors, %0d two-alarm plans, %0d mismatches",
             sb.empty_mask, sb.two_alarms, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
